[design/gbat_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gbat_pkg;

    // Command codes
    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Aggregation modes (codes 5 to 7 act as count)
    localparam logic [2:0] MODE_COUNT = 3'd0;
    localparam logic [2:0] MODE_SUM   = 3'd1;
    localparam logic [2:0] MODE_AVG   = 3'd2;
    localparam logic [2:0] MODE_MIN   = 3'd3;
    localparam logic [2:0] MODE_MAX   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ROW_ERR = 2'd1;
    localparam logic [1:0] ST_COL_ERR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_AGG_MODE = 2'd0;
    localparam logic [1:0] CFG_TWO_DIM  = 2'd1;
    localparam logic [1:0] CFG_ROW_CNT  = 2'd2;
    localparam logic [1:0] CFG_COL_CNT  = 2'd3;

    // Linear cell address before wrapping: 63*127+63 fits in 13 bits
    localparam int ADDR_W = 13;

    typedef struct packed {
        logic [2:0] agg_mode;
        logic       two_dim;
        logic [6:0] row_count;
        logic [6:0] col_count;
    } t_cfg;

    // One classified item on its way from front to back
    typedef struct packed {
        logic               cmd;
        logic [1:0]         status;
        logic signed [47:0] sample_value;
    } t_job;

endpackage
`default_nettype wire

[design/gbat_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// Input item channel
interface gbat_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [5:0]         row_key;
    logic [5:0]         col_key;
    logic signed [47:0] sample_value;
    modport source(output valid, cmd, row_key, col_key, sample_value, input ready);
    modport sink(input valid, cmd, row_key, col_key, sample_value, output ready);
endinterface

// Result item channel
interface gbat_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        cell_count;
    logic signed [63:0] cell_value;
    modport source(output valid, status, cell_count, cell_value, input ready);
    modport sink(input valid, status, cell_count, cell_value, output ready);
endinterface

// Configuration write channel
interface gbat_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/gbat_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module gbat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[design/gbat_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module gbat_queue #(
    parameter int WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    // Two-entry circular queue
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[design/gbat_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module gbat_front #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int CELL_DEPTH = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gbat_pkg::t_cfg  i_cfg,
    input  wire logic            i_hold,
    gbat_in_if.sink              i_in,
    output logic                 o_push,
    output gbat_pkg::t_job       o_job,
    output logic [(CELL_DEPTH > 1 ? $clog2(CELL_DEPTH) : 1)-1:0] o_addr,
    input  wire logic            i_full
);

    localparam int AW = gbat_pkg::ADDR_W;
    localparam int CW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    // floor(2^AW / depth); estimate of addr/depth is low by at most one
    localparam logic [AW:0]   RECIP = (AW + 1)'((32'd1 << AW) / CELL_DEPTH);
    localparam logic [33:0]   DEP   = 34'(CELL_DEPTH);

    typedef enum logic [1:0] {
        F_IDLE,
        F_QUOT,
        F_REM,
        F_PUSH
    } t_state;

    t_state          r_state;
    gbat_pkg::t_job  r_job;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_q;
    logic [AW-1:0]   r_rem;

    logic            w_accept;
    logic            w_row_ok;
    logic            w_col_ok;
    logic [6:0]      w_clim;
    logic [AW-1:0]   w_lin;
    logic [1:0]      w_status;
    logic [2*AW:0]   w_qprod;
    logic [33:0]     w_dprod;
    logic [AW-1:0]   w_fix;

    assign i_in.ready = (r_state == F_IDLE) && !i_hold;
    assign w_accept   = i_in.valid && i_in.ready;

    // Key range checks: limit is min(register, maximum)
    assign w_row_ok = (7'(i_in.row_key) < i_cfg.row_count) && (32'(i_in.row_key) < MAX_ROWS);
    assign w_col_ok = (7'(i_in.col_key) < i_cfg.col_count) && (32'(i_in.col_key) < MAX_COLS);
    assign w_clim   = (32'(i_cfg.col_count) < MAX_COLS) ? i_cfg.col_count : 7'(MAX_COLS);

    always_comb begin
        if (!w_row_ok) begin
            w_status = gbat_pkg::ST_ROW_ERR;
        end else if (i_cfg.two_dim && !w_col_ok) begin
            w_status = gbat_pkg::ST_COL_ERR;
        end else begin
            w_status = gbat_pkg::ST_OK;
        end
    end

    // Linear address row*clim + col, or row alone
    assign w_lin = i_cfg.two_dim
                 ? 13'(AW'(i_in.row_key) * AW'(w_clim)) + AW'(i_in.col_key)
                 : AW'(i_in.row_key);

    // Wrap modulo depth: reciprocal quotient, remainder, one correction
    assign w_qprod = (2 * AW + 1)'(r_addr) * (2 * AW + 1)'(RECIP);
    assign w_dprod = 34'(r_q) * DEP;
    assign w_fix   = (21'(r_rem) >= 21'(CELL_DEPTH)) ? r_rem - AW'(CELL_DEPTH) : r_rem;

    assign o_push = (r_state == F_PUSH);
    assign o_job  = r_job;
    assign o_addr = CW'(w_fix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_job.cmd          <= i_in.cmd;
                        r_job.status       <= w_status;
                        r_job.sample_value <= i_in.sample_value;
                        r_addr             <= w_lin;
                        r_rem              <= '0;
                        r_state            <= (w_status == gbat_pkg::ST_OK) ? F_QUOT : F_PUSH;
                    end
                end
                F_QUOT: begin
                    r_q     <= w_qprod[AW +: AW];
                    r_state <= F_REM;
                end
                F_REM: begin
                    r_rem   <= r_addr - w_dprod[AW-1:0];
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[design/gbat_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module gbat_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic      [63:0] o_quotient
);

    // Restoring divider, one quotient bit per cycle
    logic        r_busy;
    logic [5:0]  r_step;
    logic [63:0] r_dvd;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_trial    = {r_rem, r_dvd[63]};
    assign w_ge       = (w_trial >= {1'b0, r_dvs});
    assign w_diff     = w_trial - {1'b0, r_dvs};
    assign o_quotient = r_dvd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            o_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                o_done <= 1'b0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[31:0] : w_trial[31:0];
                r_dvd  <= {r_dvd[62:0], w_ge};
                r_step <= r_step + 6'd1;
                // done pulses after the last quotient bit
                o_done <= (r_step == 6'd63);
                if (r_step == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end else begin
                o_done <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[design/gbat_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module gbat_back #(
    parameter int CELL_DEPTH = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gbat_pkg::t_cfg  i_cfg,
    input  wire logic            i_empty,
    output logic                 o_pop,
    input  wire gbat_pkg::t_job  i_job,
    input  wire logic [(CELL_DEPTH > 1 ? $clog2(CELL_DEPTH) : 1)-1:0] i_addr,
    output logic                 o_clearing,
    gbat_out_if.source           o_res
);

    localparam int CW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam logic [CW-1:0] LAST = CW'(CELL_DEPTH - 1);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_EXEC,
        B_DIV,
        B_OUT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_clr;
    gbat_pkg::t_job  r_job;
    logic [CW-1:0]   r_addr;
    logic            r_neg;
    logic [1:0]      r_st;
    logic [31:0]     r_cnt;
    logic [63:0]     r_val;
    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic [31:0]     r_out_count;
    logic [63:0]     r_out_value;

    logic [31:0]     w_cnt_rd;
    logic [63:0]     w_val_rd;
    logic            w_we;
    logic [CW-1:0]   w_waddr;
    logic [31:0]     w_cnt_wr;
    logic [63:0]     w_val_wr;
    logic [31:0]     w_cnt_new;
    logic [63:0]     w_val_new;
    logic [63:0]     w_smp;
    logic [63:0]     w_sum;
    logic            w_ovf;
    logic            w_div_start;
    logic            w_div_done;
    logic [63:0]     w_quot;
    logic            w_out_free;

    // Cell stores, cleared by a sweep after reset
    gbat_ram #(.WIDTH(32), .DEPTH(CELL_DEPTH)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_cnt_wr),
        .i_re    (o_pop),
        .i_raddr (i_addr),
        .o_rdata (w_cnt_rd)
    );

    gbat_ram #(.WIDTH(64), .DEPTH(CELL_DEPTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_val_wr),
        .i_re    (o_pop),
        .i_raddr (i_addr),
        .o_rdata (w_val_rd)
    );

    gbat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_val_rd[63] ? 64'd0 - w_val_rd : w_val_rd),
        .i_divisor  (w_cnt_rd),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign o_clearing = (r_state == B_CLEAR);
    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign w_out_free = !r_out_valid || o_res.ready;

    // Accumulate: saturating sum, first-sample min/max, saturating count
    assign w_smp = {{16{r_job.sample_value[47]}}, r_job.sample_value};
    assign w_sum = w_val_rd + w_smp;
    assign w_ovf = (w_val_rd[63] == w_smp[63]) && (w_sum[63] != w_val_rd[63]);
    assign w_cnt_new = (w_cnt_rd == 32'hFFFF_FFFF) ? w_cnt_rd : w_cnt_rd + 32'd1;

    always_comb begin
        case (i_cfg.agg_mode)
            gbat_pkg::MODE_SUM, gbat_pkg::MODE_AVG: begin
                if (w_ovf) begin
                    w_val_new = w_val_rd[63] ? 64'h8000_0000_0000_0000
                                             : 64'h7FFF_FFFF_FFFF_FFFF;
                end else begin
                    w_val_new = w_sum;
                end
            end
            gbat_pkg::MODE_MIN: begin
                w_val_new = (w_cnt_rd == 32'd0 || $signed(w_smp) < $signed(w_val_rd))
                          ? w_smp : w_val_rd;
            end
            gbat_pkg::MODE_MAX: begin
                w_val_new = (w_cnt_rd == 32'd0 || $signed(w_val_rd) < $signed(w_smp))
                          ? w_smp : w_val_rd;
            end
            default: begin
                w_val_new = w_val_rd;
            end
        endcase
    end

    // Write port: clearing sweep or accumulate write-back
    assign w_we     = (r_state == B_CLEAR)
                   || (r_state == B_EXEC && r_job.cmd == gbat_pkg::CMD_ACC);
    assign w_waddr  = (r_state == B_CLEAR) ? r_clr : r_addr;
    assign w_cnt_wr = (r_state == B_CLEAR) ? 32'd0 : w_cnt_new;
    assign w_val_wr = (r_state == B_CLEAR) ? 64'd0 : w_val_new;

    assign w_div_start = (r_state == B_EXEC) && (r_job.cmd == gbat_pkg::CMD_READ)
                      && (i_cfg.agg_mode == gbat_pkg::MODE_AVG) && (w_cnt_rd != 32'd0);

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.cell_count = r_out_count;
    assign o_res.cell_value = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output register drains independently; B_OUT reloads it itself
            if (r_out_valid && o_res.ready && r_state != B_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == LAST) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job  <= i_job;
                        r_addr <= i_addr;
                        r_st   <= i_job.status;
                        r_cnt  <= '0;
                        r_val  <= '0;
                        r_state <= (i_job.status == gbat_pkg::ST_OK) ? B_EXEC : B_OUT;
                    end
                end
                B_EXEC: begin
                    // average read of a non-empty cell goes through the divider
                    if (w_div_start) begin
                        r_state <= B_DIV;
                    end else begin
                        r_state <= B_OUT;
                    end
                    if (r_job.cmd == gbat_pkg::CMD_READ) begin
                        r_cnt <= w_cnt_rd;
                        case (i_cfg.agg_mode)
                            gbat_pkg::MODE_SUM, gbat_pkg::MODE_MIN, gbat_pkg::MODE_MAX: begin
                                r_val <= w_val_rd;
                            end
                            gbat_pkg::MODE_AVG: begin
                                r_neg <= w_val_rd[63];
                            end
                            default: begin
                                r_val <= '0;
                            end
                        endcase
                    end
                end
                B_DIV: begin
                    if (w_div_done) begin
                        r_val   <= r_neg ? 64'd0 - w_quot : w_quot;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_st;
                        r_out_count  <= r_cnt;
                        r_out_value  <= r_val;
                        r_state      <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[design/group_by_aggregation_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Group-by aggregation table: folds records into a store of row/column cells.
// Channels: i_in takes items (cmd accumulate or read, row_key, col_key,
// sample_value); o_res returns exactly one result per item, in order
// (status, cell_count, cell_value); i_cfg writes the mode, dimension flag,
// row count and column count, and is always ready.
// Flow: the front stage takes an item and wraps the cell address (F_QUOT,
// F_REM) before pushing it in F_PUSH; the back stage pops it, reads the cell
// (registered read), writes it back or forms the result in B_EXEC, and loads
// the output register in B_OUT, which raises o_res.valid. A key error skips
// the wrap and B_EXEC. An average read of a non-empty cell also goes through
// the bit-serial divider (B_DIV) before B_OUT.
// The front takes a new item only after it has pushed the last one; an
// average read holds the back stage while the divider runs.
// A two-entry queue between front and back lets the front take new items
// while the back is busy or the receiver stalls; a stalled o_res holds its
// result and back-pressures through the queue to i_in.ready.
// Reset: registers return to mode count, two-dimensional, 64 rows and 64
// columns, and the cell stores are swept to zero, one cell per cycle, through
// all CELL_DEPTH cells, during which i_in.ready stays low.
module group_by_aggregation_table #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int CELL_DEPTH = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gbat_in_if.sink    i_in,
    gbat_out_if.source o_res,
    gbat_cfg_if.sink   i_cfg
);

    localparam int CW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int JOB_W = $bits(gbat_pkg::t_job);

    gbat_pkg::t_cfg  r_cfg;
    logic            w_push;
    gbat_pkg::t_job  w_front_job;
    logic [CW-1:0]   w_front_addr;
    logic            w_full;
    logic            w_pop;
    logic            w_empty;
    logic [JOB_W+CW-1:0] w_head;
    logic            w_clearing;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.agg_mode  <= gbat_pkg::MODE_COUNT;
            r_cfg.two_dim   <= 1'b1;
            r_cfg.row_count <= 7'd64;
            r_cfg.col_count <= 7'd64;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gbat_pkg::CFG_AGG_MODE: r_cfg.agg_mode  <= i_cfg.data[2:0];
                gbat_pkg::CFG_TWO_DIM:  r_cfg.two_dim   <= i_cfg.data[0];
                gbat_pkg::CFG_ROW_CNT:  r_cfg.row_count <= i_cfg.data;
                gbat_pkg::CFG_COL_CNT:  r_cfg.col_count <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    gbat_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .CELL_DEPTH (CELL_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_hold  (w_clearing),
        .i_in    (i_in),
        .o_push  (w_push),
        .o_job   (w_front_job),
        .o_addr  (w_front_addr),
        .i_full  (w_full)
    );

    gbat_queue #(.WIDTH(JOB_W + CW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_job, w_front_addr}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    gbat_back #(.CELL_DEPTH(CELL_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .i_job      (w_head[JOB_W+CW-1:CW]),
        .i_addr     (w_head[CW-1:0]),
        .o_clearing (w_clearing),
        .o_res      (o_res)
    );

endmodule
`default_nettype wire
